@@ hdl/cc20_pkg.sv @@
// Shared types, constants and round functions for the ChaCha20 keystream block.
package cc20_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int WORDS         = 16;
  localparam int IDX_W         = 4;
  localparam int STEP_W        = $clog2(4 * DOUBLE_ROUNDS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(4 * DOUBLE_ROUNDS - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WORDS - 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [31:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef word_t [WORDS-1:0] matrix_t;

  // Register indexes
  localparam cfg_idx_t CFG_KEY_01   = 3'd0;
  localparam cfg_idx_t CFG_KEY_23   = 3'd1;
  localparam cfg_idx_t CFG_KEY_45   = 3'd2;
  localparam cfg_idx_t CFG_KEY_67   = 3'd3;
  localparam cfg_idx_t CFG_NONCE_01 = 3'd4;
  localparam cfg_idx_t CFG_NONCE_2  = 3'd5;

  // "expand 32-byte k"
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  typedef struct packed {
    logic  load;   // build a fresh state from config and counter
    logic  round;  // apply one half quarter-round on all four lanes
    logic  diag;   // diagonal lanes instead of columns
    logic  half;   // second half of the quarter round (rotates 8, 7)
    logic  emit;   // load the output register with word idx
    idx_t  idx;
  } cc20_cmd_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    rotl = (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  // Half of a quarter round: two dependent adds.
  function automatic quad_t qr_half(input quad_t q, input logic second);
    quad_t       r;
    logic [4:0]  s1;
    logic [4:0]  s2;
    s1  = second ? 5'd8 : 5'd16;
    s2  = second ? 5'd7 : 5'd12;
    r.a = q.a + q.b;
    r.d = rotl(q.d ^ r.a, s1);
    r.c = q.c + r.d;
    r.b = rotl(q.b ^ r.c, s2);
    qr_half = r;
  endfunction

endpackage

@@ hdl/cc20_if.sv @@
// Request channel interfaces: counter in, keystream words out.
interface cc20_in_if;
  import cc20_pkg::*;
  logic  valid;
  logic  ready;
  word_t block_counter;
  modport source (output valid, output block_counter, input ready);
  modport sink   (input valid, input block_counter, output ready);
endinterface

interface cc20_out_if;
  import cc20_pkg::*;
  logic  valid;
  logic  ready;
  word_t keystream_word;
  idx_t  word_index;
  logic  last_word;
  modport source (output valid, output keystream_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input keystream_word, input word_index,
                  input last_word, output ready);
endinterface

@@ hdl/cc20_ctrl.sv @@
// Sequencer for the ChaCha20 block: accept, round steps, word emission.
module cc20_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cc20_pkg::cc20_cmd_t cmd
);
  import cc20_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  idx_t              emit_idx_r, emit_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    emit_idx_nxt = emit_idx_r;
    cmd          = '0;
    cmd.diag     = step_r[1];
    cmd.half     = step_r[0];
    cmd.idx      = emit_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        step_nxt  = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          emit_idx_nxt = '0;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit     = 1'b1;
          emit_idx_nxt = emit_idx_r + 1'b1;
          if (emit_idx_r == LAST_IDX) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/cc20_dp.sv @@
// ChaCha20 datapath: key/nonce registers, state matrices, round lanes, output register.
module cc20_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  cc20_pkg::cfg_idx_t  cfg_index,
  input  cc20_pkg::cfg_data_t cfg_wdata,
  input  cc20_pkg::word_t     block_counter,
  input  cc20_pkg::cc20_cmd_t cmd,
  output cc20_pkg::word_t     keystream_word,
  output cc20_pkg::idx_t      word_index,
  output logic                last_word
);
  import cc20_pkg::*;

  word_t   key_r [8];
  word_t   nonce_r [3];
  matrix_t init_r, work_r, work_nxt, fresh;
  word_t   out_word_r;
  idx_t    out_idx_r;
  logic    out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) key_r[i] <= '0;
      for (int i = 0; i < 3; i++) nonce_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_01:   {key_r[1], key_r[0]}     <= cfg_wdata;
        CFG_KEY_23:   {key_r[3], key_r[2]}     <= cfg_wdata;
        CFG_KEY_45:   {key_r[5], key_r[4]}     <= cfg_wdata;
        CFG_KEY_67:   {key_r[7], key_r[6]}     <= cfg_wdata;
        CFG_NONCE_01: {nonce_r[1], nonce_r[0]} <= cfg_wdata;
        CFG_NONCE_2:  nonce_r[2]               <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fresh[0]  = SIGMA_0;
    fresh[1]  = SIGMA_1;
    fresh[2]  = SIGMA_2;
    fresh[3]  = SIGMA_3;
    for (int i = 0; i < 8; i++) fresh[4 + i] = key_r[i];
    fresh[12] = block_counter;
    fresh[13] = nonce_r[0];
    fresh[14] = nonce_r[1];
    fresh[15] = nonce_r[2];
  end

  // Four independent lanes; diagonal lanes rotate rows b, c, d by 1, 2, 3.
  always_comb begin
    logic [1:0] db;
    logic [1:0] ln;
    idx_t       ia, ib, ic, id;
    quad_t      qi, qo;
    work_nxt = work_r;
    db       = cmd.diag ? 2'd1 : 2'd0;
    for (int q = 0; q < 4; q++) begin
      ln = 2'(q);
      ia = {2'b00, ln};
      ib = {2'b01, 2'(ln + db)};
      ic = {2'b10, 2'(ln + {db[0], 1'b0})};
      id = {2'b11, 2'(ln + db + {db[0], 1'b0})};
      qi = '{a: work_r[ia], b: work_r[ib], c: work_r[ic], d: work_r[id]};
      qo = qr_half(qi, cmd.half);
      work_nxt[ia] = qo.a;
      work_nxt[ib] = qo.b;
      work_nxt[ic] = qo.c;
      work_nxt[id] = qo.d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      init_r <= fresh;
      work_r <= fresh;
    end else if (cmd.round) begin
      work_r <= work_nxt;
    end
    if (cmd.emit) begin
      out_word_r <= work_r[cmd.idx] + init_r[cmd.idx];
      out_idx_r  <= cmd.idx;
      out_last_r <= (cmd.idx == LAST_IDX);
    end
  end

  assign keystream_word = out_word_r;
  assign word_index     = out_idx_r;
  assign last_word      = out_last_r;

endmodule

@@ hdl/chacha20_block_keystream.sv @@
// ChaCha20 block function (RFC 7539): one 32-bit block counter in, sixteen keystream words out.
// Each request carries a block counter; the block builds the state from the constants, the
// 256-bit key and 96-bit nonce in the configuration registers and the counter, runs ten double
// rounds and streams the sixteen words of state plus initial state, word 0 first, last word
// flagged. A block is accepted, then run through the round steps (per double round: columns
// then diagonals, each in two halves of a quarter round on four lanes at once, two dependent
// 32-bit adds per step) and emitted word by word, held on output stalls. A new counter is
// taken only after the previous block's sixteenth word is in the output register. Load the key
// and nonce only while no block is in flight; a write takes effect from the next request.
module chacha20_block_keystream (
  input  logic                clk,
  input  logic                rst_n,
  cc20_in_if.sink             in_ch,
  cc20_out_if.source          out_ch,
  input  logic                cfg_we,
  input  cc20_pkg::cfg_idx_t  cfg_index,
  input  cc20_pkg::cfg_data_t cfg_wdata
);
  import cc20_pkg::*;

  cc20_cmd_t cmd;

  cc20_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  cc20_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .block_counter  (in_ch.block_counter),
    .cmd            (cmd),
    .keystream_word (out_ch.keystream_word),
    .word_index     (out_ch.word_index),
    .last_word      (out_ch.last_word)
  );

  // A taken request starts the rounds; no second request right behind it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while a block is in flight");

  // When idle, the output register is empty or holds the final word of the last block.
  a_idle_out_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid || out_ch.last_word)
    else $error("idle with an unfinished block in the output register");

  // Once the final word is taken no further word appears until a new block is run.
  a_no_word_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_word |=> !out_ch.valid)
    else $error("word presented after the last word of a block");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for chacha20_block_keystream: counter requests in, keystream words out.
module tb_top;
  import cc20_pkg::*;

  localparam int NUM_REGS    = int'(CFG_NONCE_2) + 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 80;
  localparam int MAX_REPORTS = 10;

  // indexes past the register list; writes there must be dropped
  localparam cfg_idx_t CFG_SPARE_6 = 3'd6;
  localparam cfg_idx_t CFG_SPARE_7 = 3'd7;

  typedef struct {
    word_t ks;
    idx_t  idx;
    logic  last;
  } ks_word_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  cc20_in_if  in_ch ();
  cc20_out_if out_ch ();

  chacha20_block_keystream DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  word_t     counter_q [$];
  ks_word_t  expected_words [$];
  ks_word_t  exp_w;
  cfg_data_t key_nonce_regs [NUM_REGS];
  cfg_data_t next_regs [NUM_REGS];
  int        src_idle_pct;
  int        sink_idle_pct;
  int        error_count;
  int        cycle_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic word_t rol32(input word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Builds the block state from the shadow key/nonce and the counter, mixes it and
  // queues the sixteen output words.
  function automatic void predict_keystream(input word_t ctr);
    word_t    init_m [16];
    word_t    mix_m [16];
    int       a;
    int       b;
    int       c;
    int       d;
    ks_word_t e;
    init_m[0] = SIGMA_0;
    init_m[1] = SIGMA_1;
    init_m[2] = SIGMA_2;
    init_m[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      init_m[4 + 2 * i] = key_nonce_regs[i][31:0];
      init_m[5 + 2 * i] = key_nonce_regs[i][63:32];
    end
    init_m[12] = ctr;
    init_m[13] = key_nonce_regs[CFG_NONCE_01][31:0];
    init_m[14] = key_nonce_regs[CFG_NONCE_01][63:32];
    init_m[15] = key_nonce_regs[CFG_NONCE_2][31:0];
    mix_m = init_m;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      for (int q = 0; q < 8; q++) begin
        // q 0..3 columns, q 4..7 diagonals
        a = q % 4;
        b = 4 + ((q < 4) ? q : (q + 1) % 4);
        c = 8 + ((q < 4) ? q : (q + 2) % 4);
        d = 12 + ((q < 4) ? q : (q + 3) % 4);
        mix_m[a] = mix_m[a] + mix_m[b]; mix_m[d] = rol32(mix_m[d] ^ mix_m[a], 16);
        mix_m[c] = mix_m[c] + mix_m[d]; mix_m[b] = rol32(mix_m[b] ^ mix_m[c], 12);
        mix_m[a] = mix_m[a] + mix_m[b]; mix_m[d] = rol32(mix_m[d] ^ mix_m[a], 8);
        mix_m[c] = mix_m[c] + mix_m[d]; mix_m[b] = rol32(mix_m[b] ^ mix_m[c], 7);
      end
    end
    for (int i = 0; i < 16; i++) begin
      e.ks   = mix_m[i] + init_m[i];
      e.idx  = idx_t'(i);
      e.last = (i == 15);
      expected_words.push_back(e);
    end
  endfunction

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR @%0t: %s", $time, msg);
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= CFG_NONCE_2)
      key_nonce_regs[idx] = (idx == CFG_NONCE_2) ? {32'h0, v[31:0]} : v;
  endtask

  task automatic load_regs();
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(cfg_idx_t'(i), next_regs[i]);
  endtask

  // no request pending, none in flight, every keystream word back
  task automatic wait_idle();
    do
      @(negedge clk);
    while (counter_q.size() != 0 || in_ch.valid || expected_words.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_keystream(in_ch.block_counter);
      if (!in_ch.valid || in_ch.ready) begin
        if (counter_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_ch.valid         <= 1'b1;
          in_ch.block_counter <= counter_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // keystream monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          note_failure($sformatf("unexpected word %h idx %0d last %b",
                                 out_ch.keystream_word, out_ch.word_index, out_ch.last_word));
        end else begin
          exp_w = expected_words.pop_front();
          if (out_ch.keystream_word !== exp_w.ks || out_ch.word_index !== exp_w.idx ||
              out_ch.last_word !== exp_w.last)
            note_failure($sformatf("expected %h idx %0d last %b, got %h idx %0d last %b",
                                   exp_w.ks, exp_w.idx, exp_w.last, out_ch.keystream_word,
                                   out_ch.word_index, out_ch.last_word));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int pick;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_KEY_01;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.block_counter = '0;
    out_ch.ready        = 1'b0;
    error_count         = 0;
    cycle_count         = 0;
    src_idle_pct        = 24;
    sink_idle_pct       = 85;
    for (int i = 0; i < NUM_REGS; i++)
      key_nonce_regs[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset key and nonce (all zero), counter extremes
    counter_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF};
    wait_idle();

    // every register all ones; the nonce word 2 write carries extra high bits
    for (int i = 0; i < NUM_REGS; i++)
      next_regs[i] = '1;
    load_regs();
    counter_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    wait_idle();

    // standard test key and nonce, junk in the upper half of nonce word 2
    next_regs[CFG_KEY_01]   = {32'h0706_0504, 32'h0302_0100};
    next_regs[CFG_KEY_23]   = {32'h0f0e_0d0c, 32'h0b0a_0908};
    next_regs[CFG_KEY_45]   = {32'h1716_1514, 32'h1312_1110};
    next_regs[CFG_KEY_67]   = {32'h1f1e_1d1c, 32'h1b1a_1918};
    next_regs[CFG_NONCE_01] = {32'h4a00_0000, 32'h0900_0000};
    next_regs[CFG_NONCE_2]  = {32'hFFFF_FFFF, 32'h0000_0000};
    load_regs();
    counter_q = '{32'h0000_0001, 32'h0000_0000};
    wait_idle();

    // writes past the register list must leave the state untouched
    write_reg(CFG_SPARE_6, '1);
    write_reg(CFG_SPARE_7, {$urandom, $urandom});
    counter_q.push_back(32'h0000_0001);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 24; sink_idle_pct = 85; end
        1: begin src_idle_pct = 85; sink_idle_pct = 24; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        for (int i = 0; i < NUM_REGS; i++) begin
          pick = $urandom_range(3);
          if (pick == 0)
            next_regs[i] = '0;
          else if (pick == 1)
            next_regs[i] = '1;
          else
            next_regs[i] = {$urandom, $urandom};
        end
        load_regs();
        for (int n = 0; n < 45; n++) begin
          pick = $urandom_range(99);
          if (pick < 15)
            counter_q.push_back(word_t'($urandom_range(15)));
          else if (pick < 30)
            counter_q.push_back({28'hFFF_FFFF, 4'($urandom_range(15))});
          else
            counter_q.push_back($urandom);
        end
        // sender holds off here until the whole batch has come back
        wait_idle();
      end
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
